FILE: rtl/core/assert_macros.svh
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SZA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SZA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/sza_pkg.sv
// ----------------------------------------------------------------------------
// sza_pkg
// Types, codes and header helpers for the stored ZIP archive writer.
// ----------------------------------------------------------------------------
package sza_pkg;

    localparam logic [2:0] ACT_NAME  = 3'd0;
    localparam logic [2:0] ACT_DATA  = 3'd1;
    localparam logic [2:0] ACT_CLOSE = 3'd2;
    localparam logic [2:0] ACT_FINAL = 3'd3;
    localparam logic [2:0] ACT_PULL  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BYTE    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] SIG_LOCAL   = 32'h0403_4b50;
    localparam logic [31:0] SIG_CENTRAL = 32'h0201_4b50;
    localparam logic [31:0] SIG_END     = 32'h0605_4b50;
    localparam logic [31:0] ZIP_VERSION = 32'd20;
    localparam logic [31:0] LOCAL_LEN   = 32'd30;
    localparam logic [31:0] CENTRAL_LEN = 32'd46;
    localparam logic [31:0] END_LEN     = 32'd22;
    localparam logic [7:0]  SLASH       = 8'h2F;

    typedef enum logic [2:0] {
        CMD_NAME,
        CMD_DATA,
        CMD_CLOSE,
        CMD_FINAL,
        CMD_PULL,
        CMD_BAD
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] value;
    } sza_cmd_t;

    typedef enum logic [2:0] {
        PH_COLLECT,
        PH_LHDR,
        PH_LNAME,
        PH_LDATA,
        PH_CDHDR,
        PH_CDNAME,
        PH_END,
        PH_DONE
    } phase_t;

    typedef enum logic {
        BK_IDLE,
        BK_PULL
    } back_state_t;

    function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // true when byte i lies in the n-byte field starting at 'at'
    function automatic logic fld_hit(logic [5:0] i, logic [5:0] at, logic [2:0] n);
        logic [5:0] d;
        d = i - at;
        return (i >= at) && (d < {3'd0, n});
    endfunction

    function automatic logic [7:0] fld_byte(logic [5:0] i, logic [5:0] at, logic [31:0] v);
        logic [5:0] d;
        d = i - at;
        return v[{d[1:0], 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] local_byte(logic [5:0] i, logic [31:0] crc,
                                              logic [31:0] len, logic [31:0] nlen);
        logic [7:0] b;
        b = 8'd0;
        if (fld_hit(i, 6'd0, 3'd4))       b = fld_byte(i, 6'd0, SIG_LOCAL);
        else if (fld_hit(i, 6'd4, 3'd2))  b = fld_byte(i, 6'd4, ZIP_VERSION);
        else if (fld_hit(i, 6'd14, 3'd4)) b = fld_byte(i, 6'd14, crc);
        else if (fld_hit(i, 6'd18, 3'd4)) b = fld_byte(i, 6'd18, len);
        else if (fld_hit(i, 6'd22, 3'd4)) b = fld_byte(i, 6'd22, len);
        else if (fld_hit(i, 6'd26, 3'd2)) b = fld_byte(i, 6'd26, nlen);
        return b;
    endfunction

    function automatic logic [7:0] central_byte(logic [5:0] i, logic [31:0] crc,
                                                logic [31:0] len, logic [31:0] nlen,
                                                logic [31:0] off);
        logic [7:0] b;
        b = 8'd0;
        if (fld_hit(i, 6'd0, 3'd4))       b = fld_byte(i, 6'd0, SIG_CENTRAL);
        else if (fld_hit(i, 6'd4, 3'd2))  b = fld_byte(i, 6'd4, ZIP_VERSION);
        else if (fld_hit(i, 6'd6, 3'd2))  b = fld_byte(i, 6'd6, ZIP_VERSION);
        else if (fld_hit(i, 6'd16, 3'd4)) b = fld_byte(i, 6'd16, crc);
        else if (fld_hit(i, 6'd20, 3'd4)) b = fld_byte(i, 6'd20, len);
        else if (fld_hit(i, 6'd24, 3'd4)) b = fld_byte(i, 6'd24, len);
        else if (fld_hit(i, 6'd28, 3'd2)) b = fld_byte(i, 6'd28, nlen);
        else if (fld_hit(i, 6'd42, 3'd4)) b = fld_byte(i, 6'd42, off);
        return b;
    endfunction

    function automatic logic [7:0] end_byte(logic [5:0] i, logic [31:0] cnt,
                                            logic [31:0] dbytes, logic [31:0] dstart);
        logic [7:0] b;
        b = 8'd0;
        if (fld_hit(i, 6'd0, 3'd4))       b = fld_byte(i, 6'd0, SIG_END);
        else if (fld_hit(i, 6'd8, 3'd2))  b = fld_byte(i, 6'd8, cnt);
        else if (fld_hit(i, 6'd10, 3'd2)) b = fld_byte(i, 6'd10, cnt);
        else if (fld_hit(i, 6'd12, 3'd4)) b = fld_byte(i, 6'd12, dbytes);
        else if (fld_hit(i, 6'd16, 3'd4)) b = fld_byte(i, 6'd16, dstart);
        return b;
    endfunction

endpackage

FILE: rtl/core/sza_if.sv
// ----------------------------------------------------------------------------
// sza interfaces
// Valid/ready channels for requests, responses and the configuration write.
// ----------------------------------------------------------------------------
interface sza_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] value;
    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface sza_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       archive_end;
    modport source (output valid, output status, output out_byte, output archive_end,
                    input ready);
    modport sink   (input valid, input status, input out_byte, input archive_end,
                    output ready);
endinterface

interface sza_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] base_offset;
    modport source (output valid, output base_offset, input ready);
    modport sink   (input valid, input base_offset, output ready);
endinterface

FILE: rtl/core/sza_front.sv
// ----------------------------------------------------------------------------
// sza_front
// Accepts request transactions, decodes the action and queues commands.
// ----------------------------------------------------------------------------
module sza_front (
    input  logic             clk,
    input  logic             rst_n,
    sza_req_if.sink          req,
    output logic             q_valid,
    output sza_pkg::sza_cmd_t q_item,
    input  logic             q_pop
);

    sza_pkg::sza_cmd_t slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    sza_pkg::sza_cmd_t decoded;
    logic              push;

    always_comb
    begin
        decoded.value = req.value;
        unique case (req.action)
            sza_pkg::ACT_NAME:  decoded.cmd = sza_pkg::CMD_NAME;
            sza_pkg::ACT_DATA:  decoded.cmd = sza_pkg::CMD_DATA;
            sza_pkg::ACT_CLOSE: decoded.cmd = sza_pkg::CMD_CLOSE;
            sza_pkg::ACT_FINAL: decoded.cmd = sza_pkg::CMD_FINAL;
            sza_pkg::ACT_PULL:  decoded.cmd = sza_pkg::CMD_PULL;
            default:            decoded.cmd = sza_pkg::CMD_BAD;
        endcase
    end

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

FILE: rtl/core/sza_back.sv
// ----------------------------------------------------------------------------
// sza_back
// Executes queued commands: buffers, CRC, entry table and byte emission.
// ----------------------------------------------------------------------------
module sza_back #(
    parameter int DATA_DEPTH  = 4096,
    parameter int NAME_MAX    = 64,
    parameter int MAX_ENTRIES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  sza_pkg::sza_cmd_t q_item,
    output logic              q_pop,
    sza_rsp_if.source         rsp,
    sza_cfg_if.sink           cfg
);

    localparam int LEN_W      = $clog2(DATA_DEPTH + 1);
    localparam int NL_W       = $clog2(NAME_MAX + 1);
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int DADDR_W    = $clog2(DATA_DEPTH);
    localparam int NAME_DEPTH = NAME_MAX * MAX_ENTRIES;
    localparam int NADDR_W    = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
    localparam int EADDR_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IDX_MAX    = (DATA_DEPTH > 46) ? DATA_DEPTH : 46;
    localparam int IDX_W      = $clog2(IDX_MAX + 1);
    localparam int ENT_W      = 64 + LEN_W + NL_W;

    logic [7:0]       data_mem  [DATA_DEPTH];
    logic [7:0]       name_mem  [NAME_DEPTH];
    logic [ENT_W-1:0] entry_mem [MAX_ENTRIES];

    logic [7:0]       data_rd_reg;
    logic [7:0]       name_rd_reg;
    logic [ENT_W-1:0] ent_rd_reg;

    sza_pkg::back_state_t state_reg, state_next;
    sza_pkg::phase_t      phase_reg, phase_next;
    logic [31:0]      crc_reg, crc_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;
    logic [NL_W-1:0]  cur_nlen_reg, cur_nlen_next;
    logic [CNT_W-1:0] entries_reg, entries_next;
    logic [CNT_W-1:0] ent_reg, ent_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      wpos_reg, wpos_next;
    logic [31:0]      dir_start_reg, dir_start_next;
    logic [31:0]      dir_bytes_reg, dir_bytes_next;
    logic             name_seen_reg, name_seen_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       byte_reg, byte_next;
    logic             end_reg, end_next;

    logic             data_we, name_we, ent_we;
    logic [NADDR_W-1:0] name_waddr, name_raddr;
    logic [DADDR_W-1:0] data_raddr;
    logic [EADDR_W-1:0] ent_raddr;
    logic             out_free;

    logic [31:0] e_crc, e_off, e_len, e_nlen;

    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = status_reg;
    assign rsp.out_byte = byte_reg;
    assign rsp.archive_end = end_reg;
    assign out_free    = !out_valid_reg || rsp.ready;

    // read addresses follow the current emit position
    assign data_raddr = idx_reg[DADDR_W-1:0];
    assign ent_raddr  = ent_reg[EADDR_W-1:0];
    assign name_raddr = NADDR_W'(32'(ent_raddr) * 32'(NAME_MAX) + 32'(idx_reg));
    assign name_waddr = NADDR_W'(32'(entries_reg) * 32'(NAME_MAX) + 32'(cur_nlen_reg));

    assign e_crc  = ent_rd_reg[ENT_W-1 -: 32];
    assign e_off  = ent_rd_reg[ENT_W-33 -: 32];
    assign e_len  = 32'(ent_rd_reg[NL_W +: LEN_W]);
    assign e_nlen = 32'(ent_rd_reg[NL_W-1:0]);

    always_comb
    begin
        sza_pkg::phase_t  ph;
        logic [IDX_W-1:0] ix;
        logic [CNT_W-1:0] en;

        state_next     = state_reg;
        phase_next     = phase_reg;
        crc_next       = crc_reg;
        cur_len_next   = cur_len_reg;
        cur_nlen_next  = cur_nlen_reg;
        entries_next   = entries_reg;
        ent_next       = ent_reg;
        idx_next       = idx_reg;
        wpos_next      = wpos_reg;
        dir_start_next = dir_start_reg;
        dir_bytes_next = dir_bytes_reg;
        name_seen_next = name_seen_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        byte_next      = byte_reg;
        end_next       = end_reg;
        q_pop          = 1'b0;
        data_we        = 1'b0;
        name_we        = 1'b0;
        ent_we         = 1'b0;
        ph             = phase_reg;
        ix             = idx_reg + IDX_W'(1);
        en             = ent_reg;

        unique case (state_reg)
            sza_pkg::BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = sza_pkg::ST_REFUSED;
                    byte_next      = 8'd0;
                    end_next       = 1'b0;
                    if (q_item.cmd == sza_pkg::CMD_PULL)
                    begin
                        if (phase_reg != sza_pkg::PH_COLLECT && phase_reg != sza_pkg::PH_DONE)
                        begin
                            // wait in BK_PULL for the registered memory reads
                            out_valid_next = 1'b0;
                            state_next     = sza_pkg::BK_PULL;
                        end
                    end
                    else if (phase_reg == sza_pkg::PH_COLLECT)
                    begin
                        unique case (q_item.cmd)
                            sza_pkg::CMD_NAME:
                            begin
                                name_seen_next = 1'b1;
                                if (!name_seen_reg && q_item.value == sza_pkg::SLASH)
                                begin
                                    status_next = sza_pkg::ST_OK;
                                end
                                else if (32'(cur_nlen_reg) >= 32'(NAME_MAX) ||
                                         32'(entries_reg) >= 32'(MAX_ENTRIES))
                                begin
                                    status_next = sza_pkg::ST_FULL;
                                end
                                else
                                begin
                                    name_we       = 1'b1;
                                    cur_nlen_next = cur_nlen_reg + NL_W'(1);
                                    status_next   = sza_pkg::ST_OK;
                                end
                            end
                            sza_pkg::CMD_DATA:
                            begin
                                if (32'(cur_len_reg) >= 32'(DATA_DEPTH))
                                begin
                                    status_next = sza_pkg::ST_FULL;
                                end
                                else
                                begin
                                    data_we      = 1'b1;
                                    cur_len_next = cur_len_reg + LEN_W'(1);
                                    crc_next     = sza_pkg::crc_byte(crc_reg, q_item.value);
                                    status_next  = sza_pkg::ST_OK;
                                end
                            end
                            sza_pkg::CMD_CLOSE:
                            begin
                                if (32'(entries_reg) >= 32'(MAX_ENTRIES))
                                begin
                                    status_next = sza_pkg::ST_FULL;
                                end
                                else
                                begin
                                    ent_we         = 1'b1;
                                    wpos_next      = wpos_reg + sza_pkg::LOCAL_LEN +
                                                     32'(cur_nlen_reg) + 32'(cur_len_reg);
                                    dir_bytes_next = dir_bytes_reg + sza_pkg::CENTRAL_LEN +
                                                     32'(cur_nlen_reg);
                                    entries_next   = entries_reg + CNT_W'(1);
                                    crc_next       = sza_pkg::CRC_INIT;
                                    cur_len_next   = '0;
                                    cur_nlen_next  = '0;
                                    name_seen_next = 1'b0;
                                    phase_next     = sza_pkg::PH_LHDR;
                                    idx_next       = '0;
                                    ent_next       = entries_reg;
                                    status_next    = sza_pkg::ST_OK;
                                end
                            end
                            sza_pkg::CMD_FINAL:
                            begin
                                dir_start_next = wpos_reg;
                                crc_next       = sza_pkg::CRC_INIT;
                                cur_len_next   = '0;
                                cur_nlen_next  = '0;
                                name_seen_next = 1'b0;
                                phase_next     = (entries_reg == '0) ? sza_pkg::PH_END
                                                                     : sza_pkg::PH_CDHDR;
                                idx_next       = '0;
                                ent_next       = '0;
                                status_next    = sza_pkg::ST_OK;
                            end
                            default:
                            begin
                                status_next = sza_pkg::ST_REFUSED;
                            end
                        endcase
                    end
                end
            end

            sza_pkg::BK_PULL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = sza_pkg::ST_BYTE;
                    end_next       = 1'b0;
                    state_next     = sza_pkg::BK_IDLE;
                    unique case (phase_reg)
                        sza_pkg::PH_LHDR:
                            byte_next = sza_pkg::local_byte(idx_reg[5:0], e_crc, e_len, e_nlen);
                        sza_pkg::PH_LNAME, sza_pkg::PH_CDNAME:
                            byte_next = name_rd_reg;
                        sza_pkg::PH_LDATA:
                            byte_next = data_rd_reg;
                        sza_pkg::PH_CDHDR:
                            byte_next = sza_pkg::central_byte(idx_reg[5:0], e_crc, e_len,
                                                              e_nlen, e_off);
                        sza_pkg::PH_END:
                        begin
                            byte_next = sza_pkg::end_byte(idx_reg[5:0], 32'(entries_reg),
                                                          dir_bytes_reg, dir_start_reg);
                            end_next  = (32'(idx_reg) == sza_pkg::END_LEN - 32'd1);
                        end
                        default:
                            byte_next = 8'd0;
                    endcase

                    // step past finished and empty segments
                    if (ph == sza_pkg::PH_LHDR && 32'(ix) >= sza_pkg::LOCAL_LEN)
                    begin
                        ph = sza_pkg::PH_LNAME;
                        ix = '0;
                    end
                    if (ph == sza_pkg::PH_LNAME && 32'(ix) >= e_nlen)
                    begin
                        ph = sza_pkg::PH_LDATA;
                        ix = '0;
                    end
                    if (ph == sza_pkg::PH_LDATA && 32'(ix) >= e_len)
                    begin
                        ph = sza_pkg::PH_COLLECT;
                        ix = '0;
                    end
                    if (ph == sza_pkg::PH_CDHDR && 32'(ix) >= sza_pkg::CENTRAL_LEN)
                    begin
                        ph = sza_pkg::PH_CDNAME;
                        ix = '0;
                    end
                    if (ph == sza_pkg::PH_CDNAME && 32'(ix) >= e_nlen)
                    begin
                        ph = sza_pkg::PH_CDHDR;
                        ix = '0;
                        en = ent_reg + CNT_W'(1);
                    end
                    if (ph == sza_pkg::PH_CDHDR && en >= entries_reg)
                    begin
                        ph = sza_pkg::PH_END;
                        ix = '0;
                    end
                    if (ph == sza_pkg::PH_END && 32'(ix) >= sza_pkg::END_LEN)
                    begin
                        ph = sza_pkg::PH_DONE;
                        ix = '0;
                    end
                    phase_next = ph;
                    idx_next   = ix;
                    ent_next   = en;
                end
            end

            default:
            begin
                state_next = sza_pkg::BK_IDLE;
            end
        endcase

        // base offset loads the write position only before the first entry
        if (cfg.valid && entries_reg == '0 && phase_reg == sza_pkg::PH_COLLECT)
        begin
            wpos_next = cfg.base_offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sza_pkg::BK_IDLE;
            phase_reg     <= sza_pkg::PH_COLLECT;
            crc_reg       <= sza_pkg::CRC_INIT;
            cur_len_reg   <= '0;
            cur_nlen_reg  <= '0;
            entries_reg   <= '0;
            ent_reg       <= '0;
            idx_reg       <= '0;
            wpos_reg      <= '0;
            dir_start_reg <= '0;
            dir_bytes_reg <= '0;
            name_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            cur_len_reg   <= cur_len_next;
            cur_nlen_reg  <= cur_nlen_next;
            entries_reg   <= entries_next;
            ent_reg       <= ent_next;
            idx_reg       <= idx_next;
            wpos_reg      <= wpos_next;
            dir_start_reg <= dir_start_next;
            dir_bytes_reg <= dir_bytes_next;
            name_seen_reg <= name_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        byte_reg   <= byte_next;
        end_reg    <= end_next;
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[cur_len_reg[DADDR_W-1:0]] <= q_item.value;
        end
        data_rd_reg <= data_mem[data_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[name_waddr] <= q_item.value;
        end
        name_rd_reg <= name_mem[name_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[entries_reg[EADDR_W-1:0]] <= {~crc_reg, wpos_reg,
                                                     cur_len_reg, cur_nlen_reg};
        end
        ent_rd_reg <= entry_mem[ent_raddr];
    end

endmodule

FILE: rtl/core/stored_zip_archive_writer.sv
// ----------------------------------------------------------------------------
// stored_zip_archive_writer
// Builds a stored (uncompressed) ZIP archive byte stream, one byte per pull.
// ----------------------------------------------------------------------------
// Channels: req carries action and value; rsp returns one status transaction
// per request (with out_byte and archive_end on pulls); cfg writes the base
// offset only while the block is idle, a rule for the user that the block
// does not enforce; it takes the offset only before the first entry closes.
// Requests enter a two-entry command queue; the execution engine pops one
// command at a time. Name, data, close, finalize and refused requests are
// answered directly; a pull that delivers a byte first waits in BK_PULL, as
// header, name and data bytes come from registered reads of the entry table
// and byte buffers. Rate: one item per cycle, except on stalls and pulls.
// Reset empties the queue and the response register, returns to collecting
// with no entries and a write position of zero. Buffer contents are not
// cleared; only written entries are ever read.
// When the receiver stalls, the response register holds; the queue keeps
// accepting requests until both entries are full.
// ----------------------------------------------------------------------------
module stored_zip_archive_writer #(
    parameter int DATA_DEPTH  = 4096,
    parameter int NAME_MAX    = 64,
    parameter int MAX_ENTRIES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    sza_req_if.sink   req,
    sza_rsp_if.source rsp,
    sza_cfg_if.sink   cfg
);

    logic              q_valid;
    logic              q_pop;
    sza_pkg::sza_cmd_t q_item;

    sza_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    sza_back #(
        .DATA_DEPTH  (DATA_DEPTH),
        .NAME_MAX    (NAME_MAX),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .rsp     (rsp),
        .cfg     (cfg)
    );

endmodule

FILE: rtl/core/sza_checker.sv
// ----------------------------------------------------------------------------
// sza_checker
// Port-level assertions for the archive writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sza_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic [7:0] rsp_out_byte,
    input logic       rsp_archive_end
);

    // a stalled response transaction stays offered
    `SZA_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // the final archive byte only comes with a delivered byte
    `SZA_ASSERT_IMP(a_end_is_byte, clk, rst_n, rsp_valid && rsp_archive_end,
                    rsp_status == sza_pkg::ST_BYTE)

    // non-byte responses carry a zero byte and no end mark
    `SZA_ASSERT_IMP(a_quiet_payload, clk, rst_n,
                    rsp_valid && rsp_status != sza_pkg::ST_BYTE,
                    rsp_out_byte == 8'd0 && !rsp_archive_end)

endmodule

bind stored_zip_archive_writer sza_checker u_sza_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_out_byte    (rsp.out_byte),
    .rsp_archive_end (rsp.archive_end)
);
